@@ src/jpeg_block_entropy_encoder_core_assert.svh @@
// Assertion macros used by the checker file
`ifndef JPEG_BLOCK_ENTROPY_ENCODER_CORE_ASSERT_SVH
`define JPEG_BLOCK_ENTROPY_ENCODER_CORE_ASSERT_SVH
// same-cycle implication, held off during reset
`define JBEE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("jbee check failed");
// next-cycle implication, held off during reset
`define JBEE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jbee check failed");
`endif

@@ src/jbee_pkg.sv @@
// Types, Annex K tables and code-table builders for the entropy encoder
package jbee_pkg;

  typedef struct packed {
    logic signed [10:0] coefficient;
    logic [1:0]         component;
  } in_t;

  typedef struct packed {
    logic [15:0] code_word;
    logic [4:0]  code_length;
    logic [10:0] amplitude_bits;
    logic [3:0]  amplitude_length;
    logic        block_end;
  } res_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_EVAL
  } state_e;

  typedef struct packed {
    logic load;
    logic read;
    logic eval;
  } cmd_t;

  typedef struct packed {
    logic load_last;
    logic stay;
    logic last;
  } status_t;

  localparam logic [7:0] SYM_EOB = 8'h00;
  localparam logic [7:0] SYM_ZRL = 8'hF0;
  localparam logic signed [10:0] COEF_MIN = -11'sd1023;

  // {length[4:0], code[15:0]}
  typedef logic [255:0][20:0] ac_tab_t;
  typedef logic [11:0][20:0]  dc_tab_t;

  localparam logic [7:0] DC_COUNTS [2][16] = '{
    '{8'd0,8'd1,8'd5,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0},
    '{8'd0,8'd3,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd0,8'd0,8'd0,8'd0,8'd0}
  };

  localparam logic [7:0] AC_COUNTS [2][16] = '{
    '{8'd0,8'd2,8'd1,8'd3,8'd3,8'd2,8'd4,8'd3,8'd5,8'd5,8'd4,8'd4,8'd0,8'd0,8'd1,8'h7d},
    '{8'd0,8'd2,8'd1,8'd2,8'd4,8'd4,8'd3,8'd4,8'd7,8'd5,8'd4,8'd4,8'd0,8'd1,8'd2,8'h77}
  };

  localparam logic [7:0] AC_SYMS [2][162] = '{
    '{8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,8'h13,8'h51,
      8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,8'h23,8'h42,8'hb1,8'hc1,
      8'h15,8'h52,8'hd1,8'hf0,8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0a,8'h16,8'h17,8'h18,
      8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,
      8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,
      8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,
      8'h76,8'h77,8'h78,8'h79,8'h7a,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h92,
      8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,
      8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,
      8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,
      8'hd9,8'hda,8'he1,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf1,8'hf2,
      8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa},
    '{8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,8'h51,8'h07,
      8'h61,8'h71,8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,8'ha1,8'hb1,8'hc1,8'h09,
      8'h23,8'h33,8'h52,8'hf0,8'h15,8'h62,8'h72,8'hd1,8'h0a,8'h16,8'h24,8'h34,8'he1,8'h25,
      8'hf1,8'h17,8'h18,8'h19,8'h1a,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h35,8'h36,8'h37,8'h38,
      8'h39,8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,
      8'h57,8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,
      8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
      8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,
      8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,
      8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,
      8'hd7,8'hd8,8'hd9,8'hda,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf2,
      8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa}
  };

  // canonical codes, elaboration only
  function automatic ac_tab_t ac_table(input int t);
    ac_tab_t tab;
    int code;
    int k;
    tab  = '0;
    code = 0;
    k    = 0;
    for (int len = 1; len <= 16; len++) begin
      for (int i = 0; i < int'(AC_COUNTS[t][len-1]); i++) begin
        tab[AC_SYMS[t][k]] = {5'(len), 16'(code)};
        code++;
        k++;
      end
      code = code << 1;
    end
    return tab;
  endfunction

  function automatic dc_tab_t dc_table(input int t);
    dc_tab_t tab;
    int code;
    int k;
    tab  = '0;
    code = 0;
    k    = 0;
    for (int len = 1; len <= 16; len++) begin
      for (int i = 0; i < int'(DC_COUNTS[t][len-1]); i++) begin
        tab[k] = {5'(len), 16'(code)};
        code++;
        k++;
      end
      code = code << 1;
    end
    return tab;
  endfunction

  // size category of an 11-bit magnitude
  function automatic logic [3:0] size_of(input logic [10:0] mag);
    logic [3:0] s;
    s = 4'd0;
    for (int i = 0; i < 11; i++) begin
      if (mag[i]) s = 4'(i + 1);
    end
    return s;
  endfunction

endpackage

@@ src/jbee_ctrl.sv @@
// Sequencer: load, read and evaluate phases of the block encoder
module jbee_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  jbee_pkg::status_t status_i,
  output jbee_pkg::cmd_t    cmd_o,
  output logic              busy_o
);
  import jbee_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (start_i && status_i.load_last) state_d = ST_READ;
      end
      ST_READ: state_d = ST_EVAL;
      ST_EVAL: begin
        if (status_i.stay) state_d = ST_EVAL;
        else if (status_i.last) state_d = ST_LOAD;
        else state_d = ST_READ;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_LOAD: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_READ: cmd_o.read = 1'b1;
      ST_EVAL: cmd_o.eval = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

endmodule

@@ src/jbee_dp.sv @@
// Datapath: zig-zag block store, DC predictors and symbol coding
module jbee_dp #(
  parameter int BLOCK_SIDE = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jbee_pkg::in_t     in_i,
  input  jbee_pkg::cmd_t    cmd_i,
  output jbee_pkg::status_t status_o,
  output logic              strobe_o,
  output jbee_pkg::res_t    result_o
);
  import jbee_pkg::*;

  localparam int CELLS = BLOCK_SIDE * BLOCK_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam logic [AW-1:0] LAST = AW'(CELLS - 1);

  typedef logic [CELLS-1:0][AW-1:0] zz_t;

  // raster index -> zig-zag position
  function automatic zz_t zz_table();
    zz_t tab;
    int  lst;
    int  d;
    int  pos;
    int  hi;
    int  lo;
    int  xb;
    tab = '0;
    lst = BLOCK_SIDE - 1;
    for (int y = 0; y < BLOCK_SIDE; y++) begin
      for (int x = 0; x < BLOCK_SIDE; x++) begin
        d   = x + y;
        pos = 0;
        for (int dd = 0; dd < d; dd++) begin
          hi  = (dd < lst) ? dd : lst;
          lo  = (dd > lst) ? dd - lst : 0;
          pos = pos + hi - lo + 1;
        end
        if (d % 2 == 1) begin
          xb  = (d < lst) ? d : lst;
          pos = pos + xb - x;
        end else begin
          xb  = (d > lst) ? d - lst : 0;
          pos = pos + x - xb;
        end
        tab[y * BLOCK_SIDE + x] = AW'(pos);
      end
    end
    return tab;
  endfunction

  localparam zz_t     ZZ      = zz_table();
  localparam ac_tab_t AC_TAB0 = ac_table(0);
  localparam ac_tab_t AC_TAB1 = ac_table(1);
  localparam dc_tab_t DC_TAB0 = dc_table(0);
  localparam dc_tab_t DC_TAB1 = dc_table(1);

  logic signed [10:0] mem [CELLS];
  logic signed [10:0] rd_q;
  logic [AW-1:0]      cnt_q, idx_q, run_q;
  logic [AW-1:0]      idx_d, run_d;
  logic [1:0]         comp_q;
  logic signed [10:0] pred_q [3];
  logic               strobe_q;
  res_t               res_q, res_d;
  logic               emit;

  logic signed [10:0] wr_val;
  logic               chroma;
  logic               nz;
  logic [7:0]         run_ext;
  logic signed [11:0] diff;
  logic [11:0]        dmag;
  logic [10:0]        amag;
  logic [3:0]         size;
  logic [10:0]        abits;
  logic [10:0]        amask;
  logic [7:0]         sym;
  logic [20:0]        ent;

  // load side
  assign wr_val = (in_i.coefficient < COEF_MIN) ? COEF_MIN : in_i.coefficient;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) mem[ZZ[cnt_q]] <= wr_val;
    if (cmd_i.read) rd_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      comp_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + AW'(1);
      if (cnt_q == '0) comp_q <= (in_i.component == 2'd3) ? 2'd2 : in_i.component;
    end
  end

  // evaluation
  assign chroma  = (comp_q != 2'd0);
  assign nz      = (rd_q != '0);
  assign run_ext = 8'(run_q);
  assign diff    = 12'(rd_q) - 12'(pred_q[comp_q]);

  always_comb begin
    if (idx_q == '0) begin
      dmag = diff[11] ? -diff : diff;
      amag = dmag[10:0];
    end else begin
      dmag = 12'(rd_q[10] ? -rd_q : rd_q);
      amag = dmag[10:0];
    end
    size  = size_of(amag);
    amask = 11'h7FF >> (4'd11 - size);
    if (idx_q == '0) abits = (diff[11] ? 11'(diff - 12'sd1) : diff[10:0]) & amask;
    else             abits = (rd_q[10] ? 11'(rd_q - 11'sd1) : rd_q) & amask;
  end

  assign status_o.load_last = (cnt_q == LAST);
  assign status_o.stay      = (idx_q != '0) && nz && (run_ext >= 8'd16);
  assign status_o.last      = (idx_q == LAST) && !status_o.stay;

  always_comb begin
    emit  = 1'b0;
    res_d = '0;
    sym   = SYM_EOB;
    ent   = '0;
    idx_d = (idx_q == LAST) ? '0 : idx_q + AW'(1);
    run_d = '0;
    if (idx_q == '0) begin
      emit  = 1'b1;
      ent   = chroma ? DC_TAB1[size] : DC_TAB0[size];
      res_d = {ent[15:0], ent[20:16], abits, size, 1'b0};
    end else if (!nz) begin
      run_d = run_q + AW'(1);
      if (idx_q == LAST) begin
        emit  = 1'b1;
        sym   = SYM_EOB;
        ent   = chroma ? AC_TAB1[sym] : AC_TAB0[sym];
        res_d = {ent[15:0], ent[20:16], 11'd0, 4'd0, 1'b1};
      end
    end else if (status_o.stay) begin
      // sixteen zeros go out, the coefficient is evaluated again
      emit  = 1'b1;
      idx_d = idx_q;
      run_d = AW'(run_ext - 8'd16);
      sym   = SYM_ZRL;
      ent   = chroma ? AC_TAB1[sym] : AC_TAB0[sym];
      res_d = {ent[15:0], ent[20:16], 11'd0, 4'd0, 1'b0};
    end else begin
      emit  = 1'b1;
      sym   = {run_ext[3:0], size};
      ent   = chroma ? AC_TAB1[sym] : AC_TAB0[sym];
      res_d = {ent[15:0], ent[20:16], abits, size, (idx_q == LAST)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      run_q     <= '0;
      strobe_q  <= 1'b0;
      pred_q[0] <= '0;
      pred_q[1] <= '0;
      pred_q[2] <= '0;
    end else begin
      strobe_q <= cmd_i.eval && emit;
      if (cmd_i.eval) begin
        idx_q <= idx_d;
        run_q <= run_d;
        if (idx_q == '0) pred_q[comp_q] <= rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) res_q <= res_d;
  end

  assign strobe_o = strobe_q;
  assign result_o = res_q;

endmodule

@@ src/jpeg_block_entropy_encoder_core.sv @@
// Baseline JPEG Huffman entropy encoder, top level
//
// Input: one quantised coefficient per beat in raster order, taken when
// start_i is high and busy_o is low. The component is sampled with the
// first coefficient of each block (3 is coded as 2). A block is loaded as
// BLOCK_SIDE*BLOCK_SIDE coefficients, one a cycle while start_i is high.
// After the last coefficient busy_o rises and the stored block is walked in
// zig-zag order through a single-port block store: each coefficient is read
// and then evaluated, with one extra evaluation per ZRL symbol, and busy_o
// falls again once the last cell has been evaluated; each symbol appears
// in the cycle after its evaluation.
// Output: each symbol shows on result_o for one cycle with strobe_o high;
// the final symbol of a block carries block_end. The receiver cannot stall.
// Reset clears the load position, the DC predictors and the component;
// the block store needs no clearing since each block is fully written first.
module jpeg_block_entropy_encoder_core #(
  parameter int BLOCK_SIDE = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  jbee_pkg::in_t  in_i,
  output logic           busy_o,
  output logic           strobe_o,
  output jbee_pkg::res_t result_o
);
  import jbee_pkg::*;

  cmd_t    cmd;
  status_t status;

  jbee_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  jbee_dp #(
    .BLOCK_SIDE (BLOCK_SIDE)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cmd_i    (cmd),
    .status_o (status),
    .strobe_o (strobe_o),
    .result_o (result_o)
  );

endmodule

@@ src/jbee_checker.sv @@
// Port-level checks for the entropy encoder, bound to the top level
`include "jpeg_block_entropy_encoder_core_assert.svh"
module jbee_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input logic           strobe_o,
  input jbee_pkg::res_t result_o
);
  import jbee_pkg::*;

  `JBEE_ASSERT_NOW(a_more_to_come, strobe_o && !result_o.block_end, busy_o)
  `JBEE_ASSERT_NOW(a_code_len, strobe_o,
                   result_o.code_length >= 5'd2 && result_o.code_length <= 5'd16)
  `JBEE_ASSERT_NEXT(a_end_quiet, strobe_o && result_o.block_end, !strobe_o)
  `JBEE_ASSERT_NEXT(a_load_quiet, start_i && !busy_o, !strobe_o)

endmodule

bind jpeg_block_entropy_encoder_core jbee_checker u_jbee_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .strobe_o (strobe_o),
  .result_o (result_o)
);

@@ tb/tb.sv @@
// Self-checking testbench for the baseline JPEG Huffman entropy encoder
`timescale 1ns / 100ps
module tb;
  import jbee_pkg::*;

  localparam int CELLS = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  in_t in_i = '0;
  logic busy_o;
  logic strobe_o;
  res_t result_o;

  jpeg_block_entropy_encoder_core #(.BLOCK_SIDE(8)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .in_i(in_i),
    .busy_o(busy_o), .strobe_o(strobe_o), .result_o(result_o)
  );

  always #4 clk_i = ~clk_i;

  // encoder model state
  logic signed [10:0] zz_block [CELLS];
  int unsigned fill_pos;
  logic signed [10:0] dc_pred [3];
  int unsigned blk_comp;
  res_t symbol_q [$];
  int errors;
  int symbols_seen;
  int blocks_done;

  // canonical Huffman code lookup; dc selects the DC list (symbol = size)
  function automatic void huff_code(input bit dc, input int t, input int sym,
                                    output logic [15:0] code, output logic [4:0] len);
    int c;
    int k;
    int n;
    c = 0;
    k = 0;
    code = '0;
    len = '0;
    for (int l = 1; l <= 16; l++) begin
      n = dc ? int'(DC_COUNTS[t][l-1]) : int'(AC_COUNTS[t][l-1]);
      for (int i = 0; i < n; i++) begin
        if ((dc && k == sym) || (!dc && int'(AC_SYMS[t][k]) == sym)) begin
          code = 16'(c);
          len = 5'(l);
          return;
        end
        c++;
        k++;
      end
      c = c << 1;
    end
  endfunction

  function automatic int unsigned cat_of(input int v);
    int unsigned m;
    int unsigned s;
    m = v < 0 ? -v : v;
    s = 0;
    while (m != 0) begin
      s++;
      m = m >> 1;
    end
    return s;
  endfunction

  function automatic logic [10:0] amp_of(input int v, input int unsigned s);
    int unsigned m;
    m = v < 0 ? -v : v;
    if (s == 0) return '0;
    return 11'(v < 0 ? (~m) & ((1 << s) - 1) : m);
  endfunction

  function automatic int unsigned zz_index(input int unsigned r);
    int unsigned x, y, d, pos;
    x = r % 8;
    y = r / 8;
    d = x + y;
    pos = 0;
    for (int unsigned e = 0; e < d; e++)
      pos += (e < 7 ? e : 7) - (e > 7 ? e - 7 : 0) + 1;
    if (d[0]) return pos + ((d < 7 ? d : 7) - x);
    return pos + (x - (d > 7 ? d - 7 : 0));
  endfunction

  function automatic void push_symbol(input bit dc, input int t, input int sym, input int v,
                                      input int unsigned s);
    res_t r;
    huff_code(dc, t, sym, r.code_word, r.code_length);
    r.amplitude_bits = amp_of(v, s);
    r.amplitude_length = 4'(s);
    r.block_end = 1'b0;
    symbol_q.push_back(r);
  endfunction

  // one coefficient beat into the model; codes the block on its last cell
  function automatic void predict_beat(input in_t b);
    int v, diff, c, t;
    int unsigned run, s;
    v = int'(b.coefficient);
    if (v < -1023) v = -1023;
    if (fill_pos == 0) blk_comp = b.component > 2 ? 2 : b.component;
    zz_block[zz_index(fill_pos)] = 11'(v);
    if (fill_pos < CELLS - 1) begin
      fill_pos++;
      return;
    end
    fill_pos = 0;
    t = blk_comp == 0 ? 0 : 1;
    diff = int'(zz_block[0]) - int'(dc_pred[blk_comp]);
    dc_pred[blk_comp] = zz_block[0];
    s = cat_of(diff);
    push_symbol(1'b1, t, s, diff, s);
    run = 0;
    for (int i = 1; i < CELLS; i++) begin
      c = int'(zz_block[i]);
      if (c == 0) begin
        run++;
        continue;
      end
      while (run > 15) begin
        push_symbol(1'b0, t, int'(SYM_ZRL), 0, 0);
        run -= 16;
      end
      s = cat_of(c);
      push_symbol(1'b0, t, int'((run << 4) | s), c, s);
      run = 0;
    end
    if (run > 0) push_symbol(1'b0, t, int'(SYM_EOB), 0, 0);
    symbol_q[symbol_q.size() - 1].block_end = 1'b1;
    blocks_done++;
  endfunction

  // field-by-field compare of one symbol
  function automatic void check_symbol(input res_t e, input res_t a);
    if (a.code_word !== e.code_word) begin
      $error("code_word exp %h got %h", e.code_word, a.code_word); errors++;
    end
    if (a.code_length !== e.code_length) begin
      $error("code_length exp %0d got %0d", e.code_length, a.code_length); errors++;
    end
    if (a.amplitude_bits !== e.amplitude_bits) begin
      $error("amplitude_bits exp %h got %h", e.amplitude_bits, a.amplitude_bits);
      errors++;
    end
    if (a.amplitude_length !== e.amplitude_length) begin
      $error("amplitude_length exp %0d got %0d", e.amplitude_length, a.amplitude_length);
      errors++;
    end
    if (a.block_end !== e.block_end) begin
      $error("block_end exp %0b got %0b", e.block_end, a.block_end); errors++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && strobe_o) begin
      symbols_seen++;
      if (symbol_q.size() == 0) begin
        $error("unexpected symbol %h", result_o);
        errors++;
      end else begin
        e = symbol_q.pop_front();
        check_symbol(e, result_o);
      end
    end
  end

  // drive one beat, waiting for acceptance; busy_o only moves at rising edges
  task automatic send_beat(input in_t b, input bit gaps);
    int unsigned g;
    g = gaps ? $urandom_range(0, 9) : 0;
    if (($urandom_range(0, 3) == 0) && gaps) g = 0;
    if (g != 0) begin
      start_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i <= b;
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    predict_beat(b);
  endtask

  // send a block: kind 0 mostly small values, 1 dense, 2 long zero runs, 3 extremes
  task automatic send_block(input int kind, input logic [1:0] comp, input bit gaps);
    in_t b;
    int p;
    p = $urandom_range(0, 3) == 0 ? 0 : 1;
    for (int i = 0; i < CELLS; i++) begin
      b.component = (i == 0) ? comp : 2'($urandom);
      case (kind)
        0: b.coefficient = ($urandom_range(0, 3) == 0) ? 11'($urandom) :
                           11'($signed($urandom_range(0, 6)) - 3);
        1: b.coefficient = 11'($urandom);
        2: b.coefficient = ($urandom_range(0, 24) == 0 || (i == 63 && p == 1)) ?
                           11'($urandom) : 11'd0;
        default: b.coefficient = $urandom_range(0, 1) ? 11'h400 : 11'h3FF;
      endcase
      send_beat(b, gaps);
    end
  endtask

  // directed first block: extremes laid out in raster order
  in_t dir_tab [CELLS];

  initial begin
    errors = 0;
    symbols_seen = 0;
    blocks_done = 0;
    fill_pos = 0;
    blk_comp = 0;
    foreach (dc_pred[i]) dc_pred[i] = '0;
    foreach (zz_block[i]) zz_block[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // DC -1024 (clamped), AC at both ends and small values, rest zeros, ends nonzero
    foreach (dir_tab[i]) dir_tab[i] = '{coefficient: 11'd0, component: 2'd0};
    dir_tab[0].coefficient = 11'h400;
    dir_tab[0].component = 2'd3;
    dir_tab[1].coefficient = 11'sd1023;
    dir_tab[8].coefficient = -11'sd1;
    dir_tab[9].coefficient = 11'sd1;
    dir_tab[40].coefficient = 11'h400;
    dir_tab[63].coefficient = -11'sd1023;
    foreach (dir_tab[i]) send_beat(dir_tab[i], 1'b0);
    // all-zero AC with luminance: DC symbol then EOB, both read off directly
    for (int i = 0; i < CELLS; i++) send_beat(in_t'{coefficient: (i == 0) ? 11'sd5 : 11'sd0,
                                                    component: 2'd0}, 1'b0);
    if (symbol_q.size() != 2) begin
      $error("symbol count exp 2 got %0d", symbol_q.size());
      errors++;
    end else begin
      check_symbol(res_t'{code_word: 16'h0004, code_length: 5'd3, amplitude_bits: 11'd5,
                          amplitude_length: 4'd3, block_end: 1'b0}, symbol_q[0]);
      check_symbol(res_t'{code_word: 16'h000A, code_length: 5'd4, amplitude_bits: 11'd0,
                          amplitude_length: 4'd0, block_end: 1'b1}, symbol_q[1]);
    end
    // each block kind, each component once
    for (int k = 0; k < 4; k++) send_block(k, 2'(k), 1'b1);
    // hold off until all symbols are out
    start_i <= 1'b0;
    while (symbol_q.size() != 0) @(posedge clk_i);
    send_block($urandom_range(0, 3), 2'($urandom), 1'b0);
    start_i <= 1'b0;

    while (symbol_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("covered %0d blocks, %0d symbols, all components and clamped extremes",
             blocks_done, symbols_seen);
    if (errors == 0 && symbol_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
